FILE: rtl/rpmt_pkg.sv
// Package: shared types and constants for the retry priority message table.
package rpmt_pkg;

  typedef enum logic [2:0] {
    ACT_ENQUEUE = 3'd0,
    ACT_CLAIM   = 3'd1,
    ACT_DELIVER = 3'd2,
    ACT_RETRY   = 3'd3,
    ACT_REMOVE  = 3'd4,
    ACT_DROP    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ES_PENDING  = 2'd0,
    ES_INFLIGHT = 2'd1,
    ES_DEAD     = 2'd2
  } entry_state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] msg_id;
    logic [1:0]  priority_req;
    logic [62:0] created_us;
    logic [62:0] now_us;
    logic [62:0] retry_at_us;
    logic        dead_flag;
    logic [31:0] error_code;
  } req_t;

  typedef struct packed {
    logic [1:0]  out_status;
    logic [63:0] found_id;
    logic [1:0]  found_priority;
    logic [31:0] attempts;
    logic [62:0] found_created_us;
    logic [62:0] found_retry_us;
    logic [31:0] found_error;
  } rsp_t;

  // One stored entry.
  typedef struct packed {
    logic [63:0] id;
    logic [1:0]  state;
    logic [1:0]  prio;
    logic [31:0] attempts;
    logic [62:0] created;
    logic [62:0] last_attempt;
    logic [62:0] retry;
    logic [31:0] error;
  } entry_t;

  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 6;
  localparam logic [CfgIdxW-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_DROP = 1'd1;

endpackage

FILE: rtl/rpmt_if.sv
// Interfaces: valid/ready channels for requests and responses.
interface rpmt_req_if;
  logic valid;
  logic ready;
  rpmt_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rpmt_rsp_if;
  logic valid;
  logic ready;
  rpmt_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/retry_priority_message_table_top.sv
// Top level: message table with a sequencer scanning entries through one comparator.
// Usage: requests arrive on req (valid/ready), one response per request leaves on rsp.
// Configuration: cfg_we with cfg_index 0 writes capacity_limit, 1 writes drop_policy;
// write only while idle.
// Enqueue writes the new entry at the end of the table without a scan, and a full
// queue answers ST_FULL without a write. Claim, drop and id lookups scan the table one
// entry per cycle through a single comparator; an id lookup stops at its first hit,
// and deletion copies the last entry into the freed slot. An empty table or an unused
// action answers without a scan.
// The entry memory has one read port, so the scan length sets the rate.
// Only one request is in work; req.ready is low from acceptance until the response
// has been taken. A stalled receiver holds the response in the output register.
// Reset empties the table (count 0) and restores capacity_limit 32, drop_policy 0;
// entry contents are not cleared.
module retry_priority_message_table_top #(
  parameter int ENTRIES = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [rpmt_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [rpmt_pkg::CfgDataW-1:0] cfg_data,
  rpmt_req_if.sink   req,
  rpmt_rsp_if.source rsp
);
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_WAIT  = 7'b0000100,
    S_ACT   = 7'b0001000,
    S_MOVE  = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state;
  rpmt_pkg::req_t r;
  rpmt_pkg::entry_t mem [ENTRIES];
  rpmt_pkg::entry_t rd;
  rpmt_pkg::entry_t best;
  rpmt_pkg::entry_t wr_data;
  logic [AW-1:0] rd_addr, wr_addr, best_idx, scan_idx;
  logic wr_en;
  logic [CW-1:0] count;
  logic [5:0] cap;
  logic [8:0] cap_wide;
  logic drop_policy;
  logic [CW-1:0] limit;
  logic have_best;
  logic rd_valid;
  logic [AW-1:0] rd_idx;
  logic scan_done;
  logic take, id_hit;
  rpmt_pkg::rsp_t out;

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd <= mem[rd_addr];
  end

  // Effective limit: capacity register capped at the table size
  always_comb begin
    cap_wide = 9'(cap);
    limit = (cap_wide < 9'(ENTRIES)) ? CW'(cap_wide) : CW'(ENTRIES);
  end

  rpmt_cmp u_cmp (
    .action(r.action), .drop_policy(drop_policy), .now_us(r.now_us),
    .msg_id(r.msg_id), .have_best(have_best), .cand(rd), .best(best),
    .take(take), .id_hit(id_hit)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_RESP);
  assign rsp.payload = out;
  logic lookup_act;
  assign lookup_act = (r.action == rpmt_pkg::ACT_DELIVER) ||
                      (r.action == rpmt_pkg::ACT_RETRY) ||
                      (r.action == rpmt_pkg::ACT_REMOVE);

  // Memory port control; the last entry stays addressed until it is copied
  always_comb begin
    rd_addr = scan_idx;
    wr_en = 1'b0;
    wr_addr = best_idx;
    wr_data = best;
    if (state == S_ACT) rd_addr = AW'(count - CW'(1));
    if (state == S_WAIT) rd_addr = AW'(count);
    if (state == S_WRITE) wr_en = 1'b1;
    if (state == S_MOVE) begin
      wr_en = 1'b1;
      wr_data = rd;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cap <= 6'd32;
      drop_policy <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rpmt_pkg::CFG_CAPACITY) cap <= cfg_data;
        else drop_policy <= cfg_data[0];
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            r <= req.payload;
            have_best <= 1'b0;
            scan_idx <= '0;
            rd_valid <= 1'b0;
            scan_done <= 1'b0;
            if (req.payload.action == rpmt_pkg::ACT_ENQUEUE) begin
              if (count >= limit) begin
                out <= '{out_status: rpmt_pkg::ST_FULL, default: '0};
                state <= S_RESP;
              end else begin
                best <= '{id: req.payload.msg_id, state: rpmt_pkg::ES_PENDING,
                          prio: req.payload.priority_req, attempts: '0,
                          created: req.payload.created_us, last_attempt: '0,
                          retry: '0, error: '0};
                best_idx <= AW'(count);
                count <= count + CW'(1);
                out <= '{out_status: rpmt_pkg::ST_OK, default: '0};
                state <= S_WRITE;
              end
            end else begin
              out <= '{out_status: rpmt_pkg::ST_NOT_FOUND, default: '0};
              if (req.payload.action > rpmt_pkg::ACT_DROP || count == '0) begin
                state <= S_RESP;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          // issue reads, evaluate previous read data
          rd_valid <= !scan_done;
          rd_idx <= scan_idx;
          if (!scan_done) begin
            if (CW'(scan_idx) == count - CW'(1)) scan_done <= 1'b1;
            else scan_idx <= scan_idx + AW'(1);
          end
          if (rd_valid) begin
            if (lookup_act) begin
              if (id_hit) begin
                best <= rd;
                best_idx <= rd_idx;
                have_best <= 1'b1;
                state <= S_ACT;
              end else if (rd_idx == AW'(count - CW'(1))) begin
                state <= S_RESP;
              end
            end else begin
              if (take) begin
                best <= rd;
                best_idx <= rd_idx;
                have_best <= 1'b1;
              end
              if (rd_idx == AW'(count - CW'(1))) state <= S_ACT;
            end
          end
        end
        S_WAIT: state <= S_MOVE;
        S_ACT: begin
          if (!have_best) begin
            state <= S_RESP;
          end else begin
            out.out_status <= rpmt_pkg::ST_OK;
            unique case (r.action)
              rpmt_pkg::ACT_CLAIM: begin
                best.state <= rpmt_pkg::ES_INFLIGHT;
                best.last_attempt <= r.now_us;
                if (best.attempts != 32'hFFFF_FFFF) best.attempts <= best.attempts + 32'd1;
                out.found_id <= best.id;
                out.found_priority <= best.prio;
                out.attempts <= (best.attempts != 32'hFFFF_FFFF) ?
                                best.attempts + 32'd1 : best.attempts;
                out.found_created_us <= best.created;
                out.found_retry_us <= best.retry;
                out.found_error <= best.error;
                state <= S_WRITE;
              end
              rpmt_pkg::ACT_RETRY: begin
                best.retry <= r.dead_flag ? '0 : r.retry_at_us;
                best.error <= r.error_code;
                best.state <= r.dead_flag ? rpmt_pkg::ES_DEAD : rpmt_pkg::ES_PENDING;
                state <= S_WRITE;
              end
              rpmt_pkg::ACT_DROP: begin
                out.found_id <= best.id;
                state <= S_RESP;
              end
              default: begin
                // delete: last entry addressed here, held through S_WAIT, copied in S_MOVE
                count <= count - CW'(1);
                state <= S_WAIT;
              end
            endcase
          end
        end
        S_MOVE: state <= S_RESP;
        S_WRITE: state <= S_RESP;
        S_RESP: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/rpmt_cmp.sv
// Shared compare unit: id match and whether a scanned entry beats the best.
module rpmt_cmp (
  input  logic [2:0]    action,
  input  logic          drop_policy,
  input  logic [62:0]   now_us,
  input  logic [63:0]   msg_id,
  input  logic          have_best,
  input  rpmt_pkg::entry_t cand,
  input  rpmt_pkg::entry_t best,
  output logic          take,
  output logic          id_hit
);
  logic pending;
  logic better_claim;
  logic better_drop;

  always_comb begin
    pending = (cand.state == rpmt_pkg::ES_PENDING);
    id_hit = (cand.id == msg_id);
    better_claim = (cand.prio > best.prio) ||
                   ((cand.prio == best.prio) && ((cand.retry < best.retry) ||
                   ((cand.retry == best.retry) && (cand.created < best.created))));
    if (drop_policy) begin
      better_drop = (cand.prio < best.prio) ||
                    ((cand.prio == best.prio) && (cand.created < best.created));
    end else begin
      better_drop = (cand.created < best.created);
    end
    take = 1'b0;
    if (action == rpmt_pkg::ACT_CLAIM) begin
      take = pending && (cand.retry <= now_us) && (!have_best || better_claim);
    end else if (action == rpmt_pkg::ACT_DROP) begin
      take = pending && (!have_best || better_drop);
    end
  end
endmodule

FILE: bench/tb_retry_priority_message_table_top.sv
// Testbench for the retry priority message table: directed, capacity, random and backpressure tests.
`timescale 1ns / 100ps

module tb_retry_priority_message_table_top;

  localparam int ENTRIES = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [rpmt_pkg::CfgIdxW-1:0] cfg_index;
  logic [rpmt_pkg::CfgDataW-1:0] cfg_data;

  rpmt_req_if req ();
  rpmt_rsp_if rsp ();

  retry_priority_message_table_top #(.ENTRIES(ENTRIES)) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // Table mirror used for prediction
  logic [63:0]  tbl_id [ENTRIES];
  rpmt_pkg::entry_state_t tbl_st [ENTRIES];
  logic [1:0]   tbl_pri [ENTRIES];
  logic [31:0]  tbl_att [ENTRIES];
  logic [62:0]  tbl_created [ENTRIES];
  logic [62:0]  tbl_last [ENTRIES];
  logic [62:0]  tbl_retry [ENTRIES];
  logic [31:0]  tbl_err [ENTRIES];
  int           tbl_count;
  int           cap_limit;
  bit           drop_by_prio;

  rpmt_pkg::rsp_t pending_rsp [$];
  int   fail_cnt;
  int   idle_pct;
  int   stall_pct;
  int   hold_len;
  int   quiet_cycles;
  logic [63:0] id_pool [12];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Return index of first entry with this id, -1 if absent
  function automatic int find_id(logic [63:0] id);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Delete by moving the last entry into the slot
  function automatic void drop_slot(int pos);
    int last;
    last = tbl_count - 1;
    tbl_id[pos] = tbl_id[last];
    tbl_st[pos] = tbl_st[last];
    tbl_pri[pos] = tbl_pri[last];
    tbl_att[pos] = tbl_att[last];
    tbl_created[pos] = tbl_created[last];
    tbl_last[pos] = tbl_last[last];
    tbl_retry[pos] = tbl_retry[last];
    tbl_err[pos] = tbl_err[last];
    tbl_count = last;
  endfunction

  // Apply one request to the mirror and compute the response
  function automatic rpmt_pkg::rsp_t table_response(rpmt_pkg::req_t r);
    rpmt_pkg::rsp_t o;
    int best;
    int pos;
    int lim;
    o = '0;
    o.out_status = rpmt_pkg::ST_NOT_FOUND;
    best = -1;
    lim = (cap_limit < ENTRIES) ? cap_limit : ENTRIES;
    case (r.action)
      rpmt_pkg::ACT_ENQUEUE: begin
        if (tbl_count >= lim) begin
          o.out_status = rpmt_pkg::ST_FULL;
        end else begin
          tbl_id[tbl_count] = r.msg_id;
          tbl_st[tbl_count] = rpmt_pkg::ES_PENDING;
          tbl_pri[tbl_count] = r.priority_req;
          tbl_att[tbl_count] = '0;
          tbl_created[tbl_count] = r.created_us;
          tbl_last[tbl_count] = '0;
          tbl_retry[tbl_count] = '0;
          tbl_err[tbl_count] = '0;
          tbl_count++;
          o.out_status = rpmt_pkg::ST_OK;
        end
      end
      rpmt_pkg::ACT_CLAIM: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_st[i] != rpmt_pkg::ES_PENDING || tbl_retry[i] > r.now_us) continue;
          if (best < 0 || tbl_pri[i] > tbl_pri[best] ||
              (tbl_pri[i] == tbl_pri[best] &&
               (tbl_retry[i] < tbl_retry[best] ||
                (tbl_retry[i] == tbl_retry[best] &&
                 tbl_created[i] < tbl_created[best])))) begin
            best = i;
          end
        end
        if (best >= 0) begin
          if (tbl_att[best] != 32'hFFFF_FFFF) tbl_att[best]++;
          tbl_st[best] = rpmt_pkg::ES_INFLIGHT;
          tbl_last[best] = r.now_us;
          o.out_status = rpmt_pkg::ST_OK;
          o.found_id = tbl_id[best];
          o.found_priority = tbl_pri[best];
          o.attempts = tbl_att[best];
          o.found_created_us = tbl_created[best];
          o.found_retry_us = tbl_retry[best];
          o.found_error = tbl_err[best];
        end
      end
      rpmt_pkg::ACT_DELIVER, rpmt_pkg::ACT_REMOVE: begin
        pos = find_id(r.msg_id);
        if (pos >= 0) begin
          drop_slot(pos);
          o.out_status = rpmt_pkg::ST_OK;
        end
      end
      rpmt_pkg::ACT_RETRY: begin
        pos = find_id(r.msg_id);
        if (pos >= 0) begin
          tbl_retry[pos] = r.dead_flag ? '0 : r.retry_at_us;
          tbl_err[pos] = r.error_code;
          tbl_st[pos] = r.dead_flag ? rpmt_pkg::ES_DEAD : rpmt_pkg::ES_PENDING;
          o.out_status = rpmt_pkg::ST_OK;
        end
      end
      rpmt_pkg::ACT_DROP: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_st[i] != rpmt_pkg::ES_PENDING) continue;
          if (best < 0) begin
            best = i;
          end else if (drop_by_prio) begin
            if (tbl_pri[i] < tbl_pri[best] ||
                (tbl_pri[i] == tbl_pri[best] && tbl_created[i] < tbl_created[best])) begin
              best = i;
            end
          end else if (tbl_created[i] < tbl_created[best]) begin
            best = i;
          end
        end
        if (best >= 0) begin
          o.out_status = rpmt_pkg::ST_OK;
          o.found_id = tbl_id[best];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Predict at request acceptance, check at response acceptance, watchdog
  always @(posedge clk) begin
    rpmt_pkg::rsp_t exp_r;
    rpmt_pkg::rsp_t got;
    if (!rst) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (req.valid && req.ready) begin
        pending_rsp.push_back(table_response(req.payload));
      end
      if (rsp.valid && rsp.ready) begin
        got = rsp.payload;
        if (pending_rsp.size() == 0) begin
          $error("response transaction with none expected");
          fail_cnt++;
        end else begin
          exp_r = pending_rsp.pop_front();
          if (got.out_status !== exp_r.out_status) begin
            $error("out_status exp %0d got %0d", exp_r.out_status, got.out_status);
            fail_cnt++;
          end
          if (got.found_id !== exp_r.found_id) begin
            $error("found_id exp %h got %h", exp_r.found_id, got.found_id);
            fail_cnt++;
          end
          if (got.found_priority !== exp_r.found_priority) begin
            $error("found_priority exp %0d got %0d", exp_r.found_priority,
                   got.found_priority);
            fail_cnt++;
          end
          if (got.attempts !== exp_r.attempts) begin
            $error("attempts exp %0d got %0d", exp_r.attempts, got.attempts);
            fail_cnt++;
          end
          if (got.found_created_us !== exp_r.found_created_us) begin
            $error("found_created_us exp %h got %h", exp_r.found_created_us,
                   got.found_created_us);
            fail_cnt++;
          end
          if (got.found_retry_us !== exp_r.found_retry_us) begin
            $error("found_retry_us exp %h got %h", exp_r.found_retry_us,
                   got.found_retry_us);
            fail_cnt++;
          end
          if (got.found_error !== exp_r.found_error) begin
            $error("found_error exp %h got %h", exp_r.found_error, got.found_error);
            fail_cnt++;
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("retry_priority_message_table_top verification failed");
        $finish;
      end
    end
  end

  // Response side ready: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_len > 0) begin
      rsp.ready <= 1'b0;
      hold_len <= hold_len - 1;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic rpmt_pkg::req_t mk(rpmt_pkg::action_t a, logic [63:0] id,
                                        logic [1:0] pri, logic [62:0] cr,
                                        logic [62:0] now, logic [62:0] rt,
                                        logic dead, logic [31:0] err);
    rpmt_pkg::req_t r;
    r.action = a;
    r.msg_id = id;
    r.priority_req = pri;
    r.created_us = cr;
    r.now_us = now;
    r.retry_at_us = rt;
    r.dead_flag = dead;
    r.error_code = err;
    return r;
  endfunction

  // Offer one transaction, then maybe go idle for a while
  task automatic send(rpmt_pkg::req_t r);
    req.valid <= 1'b1;
    req.payload <= r;
    do @(posedge clk); while (!req.ready);
    if ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stop offering and wait for all responses to drain
  task automatic drain();
    if (req.valid) req.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [rpmt_pkg::CfgIdxW-1:0] idx,
                           logic [rpmt_pkg::CfgDataW-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rpmt_pkg::CFG_CAPACITY) cap_limit = val;
    else drop_by_prio = val[0];
    @(posedge clk);
  endtask

  function automatic logic [62:0] rand_time();
    if ($urandom_range(9) == 0) return 63'({$urandom, $urandom});
    return 63'($urandom_range(0, 40));
  endfunction

  // Random transaction, biased toward ids that are in the table
  function automatic rpmt_pkg::req_t rand_item();
    rpmt_pkg::req_t r;
    int w;
    logic [63:0] id;
    w = $urandom_range(99);
    if (tbl_count > 0 && $urandom_range(9) < 7) id = tbl_id[$urandom_range(tbl_count - 1)];
    else if ($urandom_range(9) == 0) id = {$urandom, $urandom};
    else id = id_pool[$urandom_range(11)];
    r = mk(rpmt_pkg::ACT_ENQUEUE, id, 2'($urandom), rand_time(), rand_time(), rand_time(),
           1'($urandom_range(3) == 0), $urandom);
    if (w < 30) r.action = rpmt_pkg::ACT_ENQUEUE;
    else if (w < 55) r.action = rpmt_pkg::ACT_CLAIM;
    else if (w < 65) r.action = rpmt_pkg::ACT_DELIVER;
    else if (w < 80) r.action = rpmt_pkg::ACT_RETRY;
    else if (w < 88) r.action = rpmt_pkg::ACT_REMOVE;
    else if (w < 96) r.action = rpmt_pkg::ACT_DROP;
    else r.action = 3'($urandom_range(6, 7));
    return r;
  endfunction

  // Extremes, ties, dead letters, unknown ids, unused actions, both drop rules
  task automatic test_directed();
    send(mk(rpmt_pkg::ACT_CLAIM, '0, '0, '0, '1, '0, 1'b0, '0));
    send(mk(rpmt_pkg::ACT_DROP, '0, '0, '0, '0, '0, 1'b0, '0));
    send(mk(rpmt_pkg::ACT_ENQUEUE, '1, 2'd3, '1, '0, '0, 1'b0, '0));
    send(mk(rpmt_pkg::ACT_ENQUEUE, '0, 2'd0, '0, '0, '0, 1'b0, '0));
    send(mk(rpmt_pkg::ACT_ENQUEUE, 64'd5, 2'd3, 63'd10, '0, '0, 1'b0, '0));
    send(mk(rpmt_pkg::ACT_ENQUEUE, 64'd5, 2'd3, 63'd10, '0, '0, 1'b0, '0));
    send(mk(rpmt_pkg::ACT_DROP, '0, '0, '0, '0, '0, 1'b0, '0));
    send(mk(rpmt_pkg::ACT_CLAIM, '0, '0, '0, 63'd0, '0, 1'b0, '0));
    send(mk(rpmt_pkg::ACT_CLAIM, '0, '0, '0, '1, '0, 1'b0, '0));
    send(mk(rpmt_pkg::ACT_RETRY, 64'd5, '0, '0, '0, '1, 1'b0, 32'h8000_0000));
    send(mk(rpmt_pkg::ACT_RETRY, '1, '0, '0, '0, 63'd7, 1'b1, 32'h7FFF_FFFF));
    send(mk(rpmt_pkg::ACT_CLAIM, '0, '0, '0, 63'd6, '0, 1'b0, '0));
    send(mk(rpmt_pkg::ACT_CLAIM, '0, '0, '0, '1, '0, 1'b0, '0));
    send(mk(rpmt_pkg::ACT_RETRY, 64'd99, '0, '0, '0, '0, 1'b0, '1));
    send(mk(rpmt_pkg::ACT_DELIVER, 64'd99, '0, '0, '0, '0, 1'b0, '0));
    send(mk(rpmt_pkg::ACT_REMOVE, 64'd99, '0, '0, '0, '0, 1'b0, '0));
    send(mk(rpmt_pkg::action_t'(3'd6), '1, '1, '1, '1, '1, 1'b1, '1));
    send(mk(rpmt_pkg::action_t'(3'd7), '0, '0, '0, '0, '0, 1'b0, '0));
    send(mk(rpmt_pkg::ACT_DELIVER, '1, '0, '0, '0, '0, 1'b0, '0));
    write_reg(rpmt_pkg::CFG_DROP, 6'd1);
    send(mk(rpmt_pkg::ACT_DROP, '0, '0, '0, '0, '0, 1'b0, '0));
    send(mk(rpmt_pkg::ACT_REMOVE, '0, '0, '0, '0, '0, 1'b0, '0));
    send(mk(rpmt_pkg::ACT_DROP, '0, '0, '0, '0, '0, 1'b0, '0));
    write_reg(rpmt_pkg::CFG_DROP, 6'd0);
  endtask

  // Queue full at small, zero, lowered and out-of-range limits
  task automatic test_capacity();
    write_reg(rpmt_pkg::CFG_CAPACITY, 6'd1);
    repeat (3) send(rand_item());
    send(mk(rpmt_pkg::ACT_ENQUEUE, 64'd77, 2'd1, 63'd3, '0, '0, 1'b0, '0));
    write_reg(rpmt_pkg::CFG_CAPACITY, 6'd0);
    send(mk(rpmt_pkg::ACT_ENQUEUE, 64'd78, 2'd1, 63'd3, '0, '0, 1'b0, '0));
    write_reg(rpmt_pkg::CFG_CAPACITY, 6'd63);
    repeat (40) send(mk(rpmt_pkg::ACT_ENQUEUE, id_pool[$urandom_range(11)], 2'($urandom),
                        rand_time(), '0, '0, 1'b0, '0));
    write_reg(rpmt_pkg::CFG_CAPACITY, 6'd4);
    repeat (6) send(rand_item());
    write_reg(rpmt_pkg::CFG_CAPACITY, 6'd32);
  endtask

  // Random traffic over several idle/stall mixes and register settings
  task automatic test_random();
    int idle_mode [4] = '{0, 66, 0, 30};
    int stall_mode [4] = '{0, 0, 66, 30};
    logic [5:0] caps [4] = '{6'd32, 6'd8, 6'd20, 6'd3};
    for (int p = 0; p < 8; p++) begin
      drain();
      idle_pct = idle_mode[p % 4];
      stall_pct = stall_mode[p % 4];
      write_reg(rpmt_pkg::CFG_CAPACITY, caps[$urandom_range(3)]);
      write_reg(rpmt_pkg::CFG_DROP, 6'(p % 2));
      repeat (140) send(rand_item());
    end
  endtask

  // Long response hold-off while requests keep coming
  task automatic test_backpressure();
    drain();
    idle_pct = 0;
    stall_pct = 0;
    hold_len = HOLD_CYCLES;
    repeat (20) send(rand_item());
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.payload = '0;
    rsp.ready = 1'b0;
    fail_cnt = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    quiet_cycles = 0;
    tbl_count = 0;
    cap_limit = 32;
    drop_by_prio = 1'b0;
    foreach (id_pool[i]) id_pool[i] = {$urandom, $urandom};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_random();
    test_backpressure();
    drain();
    repeat (60) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("retry_priority_message_table_top verification clean");
    end else begin
      $display("retry_priority_message_table_top verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rpmt_pkg.sv
rtl/rpmt_if.sv
rtl/rpmt_cmp.sv
rtl/retry_priority_message_table_top.sv
bench/tb_retry_priority_message_table_top.sv
